// ===== src/tgcs_pkg.sv =====
// Shared constants, codes and controller/datapath types for the text grid block.
`timescale 1ns / 1ps

package tgcs_pkg;

    localparam int MAX_COLUMNS = 128;
    localparam int MAX_ROWS    = 64;
    localparam int COL_W       = $clog2(MAX_COLUMNS);
    localparam int ROW_W       = $clog2(MAX_ROWS);
    localparam int ADDR_W      = ROW_W + COL_W;
    localparam int CELLS       = MAX_ROWS * MAX_COLUMNS;

    localparam logic [7:0] COLS_MAX     = 8'(MAX_COLUMNS);
    localparam logic [6:0] ROWS_MAX     = 7'(MAX_ROWS);
    localparam logic [7:0] COLS_RESET   = 8'd80;
    localparam logic [6:0] ROWS_RESET   = 7'd25;
    localparam logic [7:0] NEWLINE_BYTE = 8'd10;
    localparam logic [7:0] SPACE_BYTE   = 8'h20;

    localparam logic [1:0] MODE_WRITE = 2'd0;
    localparam logic [1:0] MODE_CLEAR = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    localparam logic [1:0] CFG_COLUMNS = 2'd0;
    localparam logic [1:0] CFG_ROWS    = 2'd1;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_CHAR,
        OP_CLEAR,
        OP_READ
    } op_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_EVAL,
        ST_READ,
        ST_COPY,
        ST_COPY_LAST,
        ST_BLANK,
        ST_CHAR,
        ST_CLEAR,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic latch_in;
        logic eval;
        logic cnt_zero;
        logic copy_rd;
        logic blank_wr;
        logic clear_wr;
        logic char_wr;
        logic cell_cap;
        logic out_load;
    } tgcs_cmd_t;

    typedef struct packed {
        op_t  op;
        logic need_scroll;
        logic rows_one;
        logic copy_last;
        logic blank_last;
        logic clear_last;
        logic out_free;
    } tgcs_status_t;

endpackage

// ===== src/tgcs_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
`timescale 1ns / 1ps

module tgcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/tgcs_ctrl.sv =====
// Sequencer for the text grid: item decode, scroll copy, blanking, clear sweep, result.
`timescale 1ns / 1ps

module tgcs_ctrl import tgcs_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  tgcs_status_t status,
    output tgcs_cmd_t    cmd
);

    state_t st_reg, st_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= ST_INIT;
        end else begin
            st_reg <= st_next;
        end
    end

    always_comb begin
        st_next = st_reg;
        case (st_reg)
            ST_INIT: begin
                if (status.clear_last) st_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_valid) st_next = ST_EVAL;
            end
            ST_EVAL: begin
                case (status.op)
                    OP_CHAR: begin
                        if (!status.need_scroll) st_next = ST_CHAR;
                        else if (status.rows_one) st_next = ST_BLANK;
                        else st_next = ST_COPY;
                    end
                    OP_CLEAR: st_next = ST_CLEAR;
                    OP_READ:  st_next = ST_READ;
                    default:  st_next = ST_DONE;
                endcase
            end
            ST_READ:      st_next = ST_DONE;
            ST_COPY: begin
                if (status.copy_last) st_next = ST_COPY_LAST;
            end
            ST_COPY_LAST: st_next = ST_BLANK;
            ST_BLANK: begin
                if (status.blank_last) st_next = ST_CHAR;
            end
            ST_CHAR:      st_next = ST_DONE;
            ST_CLEAR: begin
                if (status.clear_last) st_next = ST_DONE;
            end
            ST_DONE: begin
                if (status.out_free) st_next = ST_IDLE;
            end
            default:      st_next = ST_INIT;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (st_reg)
            ST_INIT:      cmd.clear_wr = 1'b1;
            ST_IDLE: begin
                s_ready      = 1'b1;
                cmd.latch_in = s_valid;
            end
            ST_EVAL: begin
                cmd.eval     = 1'b1;
                cmd.cnt_zero = 1'b1;
            end
            ST_READ:      cmd.cell_cap = 1'b1;
            ST_COPY:      cmd.copy_rd  = 1'b1;
            ST_COPY_LAST: cmd.cnt_zero = 1'b1;
            ST_BLANK:     cmd.blank_wr = 1'b1;
            ST_CHAR:      cmd.char_wr  = 1'b1;
            ST_CLEAR:     cmd.clear_wr = 1'b1;
            ST_DONE:      cmd.out_load = status.out_free;
            default:      cmd = '0;
        endcase
    end

endmodule

// ===== src/tgcs_dp.sv =====
// Datapath: config registers, cursor, cell store, sweep counters and result register.
`timescale 1ns / 1ps

module tgcs_dp import tgcs_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic [1:0]   s_mode,
    input  logic [7:0]   s_char_byte,
    input  logic [5:0]   s_read_row,
    input  logic [6:0]   s_read_column,
    output logic         m_valid,
    input  logic         m_ready,
    output logic [7:0]   m_cell_value,
    output logic [6:0]   m_cursor_row,
    output logic [7:0]   m_cursor_column,
    output logic         m_did_scroll,
    input  logic         cfg_valid,
    input  logic [1:0]   cfg_index,
    input  logic [7:0]   cfg_data,
    input  tgcs_cmd_t    cmd,
    output tgcs_status_t status
);

    logic [7:0]       cols_reg;
    logic [6:0]       rows_reg;
    logic [6:0]       row_reg;
    logic [7:0]       col_reg;
    logic [1:0]       mode_reg;
    logic [7:0]       char_reg;
    logic [5:0]       rd_row_reg;
    logic [6:0]       rd_col_reg;
    logic [7:0]       value_reg;
    logic             scrolled_reg;
    logic [ROW_W-1:0] cnt_row_reg;
    logic [COL_W-1:0] cnt_col_reg;
    logic             copy_pend_reg;
    logic [ADDR_W-1:0] copy_dst_reg;
    logic             m_valid_reg;
    logic [7:0]       m_cell_value_reg;
    logic [6:0]       m_cursor_row_reg;
    logic [7:0]       m_cursor_column_reg;
    logic             m_did_scroll_reg;

    logic             wrap;
    logic [6:0]       row_adv;
    logic [6:0]       row_wrap;
    logic             need_scroll;
    logic             is_newline;
    logic             col_last;
    logic [6:0]       last_row;
    logic [6:0]       cfg_rows_val;
    op_t              op;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [7:0]        ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [7:0]        ram_rdata;

    // Cursor arithmetic for the wrap / pending-scroll rules.
    assign wrap        = col_reg >= cols_reg;
    assign row_adv     = (row_reg >= rows_reg) ? rows_reg : row_reg + 7'd1;
    assign row_wrap    = wrap ? row_adv : row_reg;
    assign need_scroll = row_wrap >= rows_reg;
    assign is_newline  = char_reg == NEWLINE_BYTE;
    assign last_row    = rows_reg - 7'd1;
    assign col_last    = {1'b0, cnt_col_reg} == (cols_reg - 8'd1);
    assign cfg_rows_val = cfg_data[6:0];

    always_comb begin
        case (mode_reg)
            MODE_WRITE: op = (is_newline || char_reg == 8'd0) ? OP_NONE : OP_CHAR;
            MODE_CLEAR: op = OP_CLEAR;
            MODE_READ:  op = OP_READ;
            default:    op = OP_NONE;
        endcase
    end

    assign status.op          = op;
    assign status.need_scroll = need_scroll;
    assign status.rows_one    = rows_reg == 7'd1;
    assign status.copy_last   = ({1'b0, cnt_row_reg} + 7'd2 == rows_reg) && col_last;
    assign status.blank_last  = &cnt_col_reg;
    assign status.clear_last  = (&cnt_row_reg) && (&cnt_col_reg);
    assign status.out_free    = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cols_reg <= COLS_RESET;
            rows_reg <= ROWS_RESET;
        end else if (cfg_valid) begin
            if (cfg_index == CFG_COLUMNS) begin
                if (cfg_data == 8'd0) cols_reg <= 8'd1;
                else if (cfg_data > COLS_MAX) cols_reg <= COLS_MAX;
                else cols_reg <= cfg_data;
            end else if (cfg_index == CFG_ROWS) begin
                if (cfg_rows_val == 7'd0) rows_reg <= 7'd1;
                else if (cfg_rows_val > ROWS_MAX) rows_reg <= ROWS_MAX;
                else rows_reg <= cfg_rows_val;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch_in) begin
            mode_reg   <= s_mode;
            char_reg   <= s_char_byte;
            rd_row_reg <= s_read_row;
            rd_col_reg <= s_read_column;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg      <= 7'd0;
            col_reg      <= 8'd0;
            value_reg    <= 8'd0;
            scrolled_reg <= 1'b0;
        end else begin
            if (cmd.latch_in) begin
                value_reg    <= 8'd0;
                scrolled_reg <= 1'b0;
            end
            if (cmd.eval) begin
                case (op)
                    OP_CHAR: begin
                        if (wrap) col_reg <= 8'd0;
                        row_reg      <= need_scroll ? last_row : row_wrap;
                        scrolled_reg <= need_scroll;
                    end
                    OP_CLEAR: begin
                        row_reg <= 7'd0;
                        col_reg <= 8'd0;
                    end
                    OP_NONE: begin
                        if (mode_reg == MODE_WRITE && is_newline) begin
                            row_reg <= row_adv;
                            col_reg <= 8'd0;
                        end
                    end
                    default: ;
                endcase
            end
            if (cmd.char_wr) col_reg <= col_reg + 8'd1;
            if (cmd.cell_cap) value_reg <= ram_rdata;
        end
    end

    // Sweep counters shared by the row copy, the row blank and the full clear.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_row_reg   <= '0;
            cnt_col_reg   <= '0;
            copy_pend_reg <= 1'b0;
        end else begin
            copy_pend_reg <= cmd.copy_rd;
            if (cmd.cnt_zero) begin
                cnt_row_reg <= '0;
                cnt_col_reg <= '0;
            end else if (cmd.copy_rd) begin
                if (col_last) begin
                    cnt_col_reg <= '0;
                    cnt_row_reg <= cnt_row_reg + ROW_W'(1);
                end else begin
                    cnt_col_reg <= cnt_col_reg + COL_W'(1);
                end
            end else if (cmd.blank_wr) begin
                cnt_col_reg <= cnt_col_reg + COL_W'(1);
            end else if (cmd.clear_wr) begin
                {cnt_row_reg, cnt_col_reg} <= {cnt_row_reg, cnt_col_reg} + ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.copy_rd) copy_dst_reg <= {cnt_row_reg, cnt_col_reg};
    end

    // Copy reads the row below; its data lands in the following cycle and is written one row up.
    assign ram_raddr = cmd.copy_rd ? {cnt_row_reg + ROW_W'(1), cnt_col_reg}
                                   : {rd_row_reg, rd_col_reg};

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = {row_reg[ROW_W-1:0], col_reg[COL_W-1:0]};
        ram_wdata = char_reg;
        if (copy_pend_reg) begin
            ram_we    = 1'b1;
            ram_waddr = copy_dst_reg;
            ram_wdata = ram_rdata;
        end else if (cmd.blank_wr) begin
            ram_we    = 1'b1;
            ram_waddr = {last_row[ROW_W-1:0], cnt_col_reg};
            ram_wdata = SPACE_BYTE;
        end else if (cmd.clear_wr) begin
            ram_we    = 1'b1;
            ram_waddr = {cnt_row_reg, cnt_col_reg};
            ram_wdata = SPACE_BYTE;
        end else if (cmd.char_wr) begin
            ram_we    = 1'b1;
        end
    end

    tgcs_ram #(
        .WIDTH (8),
        .DEPTH (CELLS)
    ) u_cells (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_cell_value_reg    <= value_reg;
            m_cursor_row_reg    <= row_reg;
            m_cursor_column_reg <= col_reg;
            m_did_scroll_reg    <= scrolled_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_cell_value    = m_cell_value_reg;
    assign m_cursor_row    = m_cursor_row_reg;
    assign m_cursor_column = m_cursor_column_reg;
    assign m_did_scroll    = m_did_scroll_reg;

endmodule

// ===== src/text_grid_cursor_scroll_top.sv =====
// Top level of the character-cell text grid with cursor and scroll.
//
//  channel | direction | handshake            | payload
//  s_      | in        | s_valid / s_ready    | mode, char_byte, read_row, read_column
//  m_      | out       | m_valid / m_ready    | cell_value, cursor_row, cursor_column, did_scroll
//  cfg_    | in        | cfg_valid / cfg_ready| cfg_index (0 columns, 1 rows), cfg_data
//
// Plain byte, read: eval, write/read, result; newline, ignored byte, spare mode: eval, result.
// One item at a time; the next input beat is taken while a finished result waits on m_.
// A scrolling byte first copies the in-use rows below the top up a row, in-use columns only
// (no copy for a single row), then blanks all 128 cells of the last row.
// Clear mode and the clearing pass after reset sweep all 8192 cells, one a cycle;
// no input beat is accepted during the pass, config beats are always taken.
`timescale 1ns / 1ps

module text_grid_cursor_scroll_top import tgcs_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_mode,
    input  logic [7:0] s_char_byte,
    input  logic [5:0] s_read_row,
    input  logic [6:0] s_read_column,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_cell_value,
    output logic [6:0] m_cursor_row,
    output logic [7:0] m_cursor_column,
    output logic       m_did_scroll,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);

    tgcs_cmd_t    cmd;
    tgcs_status_t status;

    assign cfg_ready = 1'b1;

    tgcs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    tgcs_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_mode          (s_mode),
        .s_char_byte     (s_char_byte),
        .s_read_row      (s_read_row),
        .s_read_column   (s_read_column),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_cell_value    (m_cell_value),
        .m_cursor_row    (m_cursor_row),
        .m_cursor_column (m_cursor_column),
        .m_did_scroll    (m_did_scroll),
        .cfg_valid       (cfg_valid),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .cmd             (cmd),
        .status          (status)
    );

`ifndef NO_ASSERTIONS
    // No input beat while the cell store is being swept or rows are moving.
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.clear_wr || cmd.copy_rd || cmd.blank_wr || cmd.char_wr) |-> !s_ready)
        else $error("input accepted while the cell store is busy");

    // Store writers never overlap on the single write port.
    a_one_writer: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.copy_rd, cmd.blank_wr, cmd.clear_wr, cmd.char_wr}))
        else $error("more than one cell store writer active");

    // A result is loaded only into a free or draining output register.
    a_out_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid || m_ready))
        else $error("result overwrote a waiting beat");

    // An accepted input beat is followed by its evaluation, during which no further beat is taken.
    a_eval_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (cmd.eval && !s_ready))
        else $error("accepted beat not evaluated");
`endif

endmodule

// ===== tb/text_grid_cursor_scroll_monitor.sv =====
// Monitor for the text grid: mirrors the grid and cursor, predicts each result and compares.
`timescale 1ns / 1ps

module text_grid_cursor_scroll_monitor import tgcs_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic [1:0] s_mode,
    input  logic [7:0] s_char_byte,
    input  logic [5:0] s_read_row,
    input  logic [6:0] s_read_column,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic [7:0] m_cell_value,
    input  logic [6:0] m_cursor_row,
    input  logic [7:0] m_cursor_column,
    input  logic       m_did_scroll,
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    output logic       drained,
    output int         fail_count,
    output int         results_seen,
    output int         scrolls_seen
);

    typedef struct packed {
        logic [7:0] cell_value;
        logic [6:0] cursor_row;
        logic [7:0] cursor_column;
        logic       did_scroll;
    } cursor_beat_t;

    logic [7:0]   cells [CELLS];
    logic [6:0]   cur_row;
    logic [7:0]   cur_col;
    logic [7:0]   grid_width;
    logic [6:0]   grid_height;
    cursor_beat_t pending_cursor_q [$];
    int           errors;
    int           n_results;
    int           n_scrolls;

    assign fail_count   = errors;
    assign results_seen = n_results;
    assign scrolls_seen = n_scrolls;

    task automatic log_mismatch(input string msg);
        errors++;
        if (errors <= 40) $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    function automatic logic [7:0] clamp_width(input logic [7:0] d);
        if (d == 8'd0) return 8'd1;
        if (d > COLS_MAX) return COLS_MAX;
        return d;
    endfunction

    function automatic logic [6:0] clamp_height(input logic [7:0] d);
        logic [6:0] v;
        v = d[6:0];
        if (v == 7'd0) return 7'd1;
        if (v > ROWS_MAX) return ROWS_MAX;
        return v;
    endfunction

    task automatic blank_grid();
        foreach (cells[i]) cells[i] = SPACE_BYTE;
    endtask

    // pending row saturates at the row count
    task automatic advance_row();
        cur_col = 8'd0;
        if (cur_row >= grid_height) cur_row = grid_height;
        else cur_row = cur_row + 7'd1;
    endtask

    // only the in-use columns move; the whole last row is blanked
    task automatic scroll_grid();
        int y;
        int x;
        for (y = 0; y + 1 < int'(grid_height); y++) begin
            for (x = 0; x < int'(grid_width); x++) begin
                cells[y * MAX_COLUMNS + x] = cells[(y + 1) * MAX_COLUMNS + x];
            end
        end
        for (x = 0; x < MAX_COLUMNS; x++) begin
            cells[(int'(grid_height) - 1) * MAX_COLUMNS + x] = SPACE_BYTE;
        end
    endtask

    task automatic apply_grid_item(input logic [1:0] mode, input logic [7:0] ch,
                                   input logic [5:0] rr, input logic [6:0] rc,
                                   output cursor_beat_t res);
        int idx;
        res = '0;
        case (mode)
            MODE_WRITE: begin
                if (ch == NEWLINE_BYTE) begin
                    advance_row();
                end else if (ch != 8'd0) begin
                    if (cur_col >= grid_width) advance_row();
                    if (cur_row >= grid_height) begin
                        scroll_grid();
                        cur_row = grid_height - 7'd1;
                        res.did_scroll = 1'b1;
                    end
                    cells[int'(cur_row) * MAX_COLUMNS + int'(cur_col)] = ch;
                    cur_col = cur_col + 8'd1;
                end
            end
            MODE_CLEAR: begin
                blank_grid();
                cur_row = 7'd0;
                cur_col = 8'd0;
            end
            MODE_READ: begin
                idx = int'(rr) * MAX_COLUMNS + int'(rc);
                if (idx < CELLS) res.cell_value = cells[idx];
            end
            default: ;
        endcase
        res.cursor_row    = cur_row;
        res.cursor_column = cur_col;
    endtask

    always @(posedge aclk) begin
        cursor_beat_t want;
        cursor_beat_t got;
        cursor_beat_t res;
        if (!aresetn) begin
            blank_grid();
            cur_row     = 7'd0;
            cur_col     = 8'd0;
            grid_width  = COLS_RESET;
            grid_height = ROWS_RESET;
            pending_cursor_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_COLUMNS: grid_width = clamp_width(cfg_data);
                    CFG_ROWS:    grid_height = clamp_height(cfg_data);
                    default: ;
                endcase
            end
            // results first, so a beat with nothing pending is never matched to this edge's input
            if (m_valid && m_ready) begin
                got = {m_cell_value, m_cursor_row, m_cursor_column, m_did_scroll};
                if (pending_cursor_q.size() == 0) begin
                    log_mismatch($sformatf("result %0d arrived with nothing pending", n_results));
                end else begin
                    want = pending_cursor_q.pop_front();
                    if (got.cell_value !== want.cell_value)
                        log_mismatch($sformatf("result %0d cell_value %02h, want %02h",
                                               n_results, got.cell_value, want.cell_value));
                    if (got.cursor_row !== want.cursor_row)
                        log_mismatch($sformatf("result %0d cursor_row %0d, want %0d",
                                               n_results, got.cursor_row, want.cursor_row));
                    if (got.cursor_column !== want.cursor_column)
                        log_mismatch($sformatf("result %0d cursor_column %0d, want %0d",
                                               n_results, got.cursor_column, want.cursor_column));
                    if (got.did_scroll !== want.did_scroll)
                        log_mismatch($sformatf("result %0d did_scroll %0b, want %0b",
                                               n_results, got.did_scroll, want.did_scroll));
                    if (want.did_scroll) n_scrolls++;
                end
                n_results++;
            end
            if (s_valid && s_ready) begin
                apply_grid_item(s_mode, s_char_byte, s_read_row, s_read_column, res);
                pending_cursor_q.push_back(res);
            end
        end
        drained <= (pending_cursor_q.size() == 0);
    end

endmodule

// ===== tb/tb_text_grid_cursor_scroll_top.sv =====
// Testbench top for the text grid: clock, reset, stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps

module tb_text_grid_cursor_scroll_top;
    import tgcs_pkg::*;

    localparam logic [1:0] MODE_SPARE  = 2'd3;
    localparam logic [1:0] CFG_SPARE_A = 2'd2;
    localparam logic [1:0] CFG_SPARE_B = 2'd3;
    localparam int QUIET_LIMIT  = 40000;  // outlasts a clear or full-grid scroll, the longest items
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 50;
    localparam int PHASES       = 14;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [1:0] s_mode;
    logic [7:0] s_char_byte;
    logic [5:0] s_read_row;
    logic [6:0] s_read_column;
    logic       m_valid;
    logic       m_ready;
    logic [7:0] m_cell_value;
    logic [6:0] m_cursor_row;
    logic [7:0] m_cursor_column;
    logic       m_did_scroll;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [1:0] cfg_index;
    logic [7:0] cfg_data;

    logic mon_drained;
    int   mon_fails;
    int   mon_results;
    int   mon_scrolls;

    bit tx_fast      = 1'b0;
    bit rx_fast      = 1'b0;
    bit hold_pending = 1'b0;
    int n_sent       = 0;
    int n_cfg        = 0;
    int quiet_cycles = 0;

    text_grid_cursor_scroll_top u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_mode          (s_mode),
        .s_char_byte     (s_char_byte),
        .s_read_row      (s_read_row),
        .s_read_column   (s_read_column),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_cell_value    (m_cell_value),
        .m_cursor_row    (m_cursor_row),
        .m_cursor_column (m_cursor_column),
        .m_did_scroll    (m_did_scroll),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    text_grid_cursor_scroll_monitor u_monitor (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_mode          (s_mode),
        .s_char_byte     (s_char_byte),
        .s_read_row      (s_read_row),
        .s_read_column   (s_read_column),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_cell_value    (m_cell_value),
        .m_cursor_row    (m_cursor_row),
        .m_cursor_column (m_cursor_column),
        .m_did_scroll    (m_did_scroll),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .drained         (mon_drained),
        .fail_count      (mon_fails),
        .results_seen    (mon_results),
        .scrolls_seen    (mon_scrolls)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("no beat moved for %0d cycles", QUIET_LIMIT);
            $display("text_grid_cursor_scroll_top verification failed");
            $finish;
        end
    end

    // receiver: random stall per beat, one long hold-off on request
    initial begin
        int stall;
        m_ready = 1'b0;
        forever begin
            stall = rx_fast ? 0 : $urandom_range(0, 19);
            if (hold_pending) begin
                hold_pending = 1'b0;
                stall = HOLD_CYCLES;
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    // valid stays high across back-to-back beats; lowered only for a gap
    task automatic send_item(input logic [1:0] mode, input logic [7:0] ch,
                             input logic [5:0] rr, input logic [6:0] rc);
        int gap;
        gap = tx_fast ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_mode        <= mode;
        s_char_byte   <= ch;
        s_read_row    <= rr;
        s_read_column <= rc;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        n_sent++;
    endtask

    // caller lowers cfg_valid after the last write of a batch
    task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        n_cfg++;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (!mon_drained);
    endtask

    initial begin
        int         ph;
        int         i;
        int         r;
        int         w;
        int         h;
        int         n_phase;
        int         nl_pct;
        logic [1:0] mode;
        logic [7:0] ch;
        logic [5:0] rr;
        logic [6:0] rc;

        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_mode        = MODE_WRITE;
        s_char_byte   = 8'd0;
        s_read_row    = 6'd0;
        s_read_column = 7'd0;
        cfg_valid     = 1'b0;
        cfg_index     = CFG_COLUMNS;
        cfg_data      = 8'd0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // reset grid 80x25: corner reads, extreme bytes, zero byte, spare mode, newline
        send_item(MODE_READ, 8'h00, 6'd0, 7'd0);
        send_item(MODE_READ, 8'hFF, 6'd63, 7'd127);
        send_item(MODE_WRITE, 8'h41, 6'd63, 7'd127);
        send_item(MODE_WRITE, 8'hFF, 6'd0, 7'd0);
        send_item(MODE_WRITE, 8'h00, 6'd21, 7'd42);
        send_item(MODE_SPARE, 8'hAA, 6'd63, 7'd127);
        send_item(MODE_WRITE, NEWLINE_BYTE, 6'd0, 7'd0);
        send_item(MODE_WRITE, 8'h01, 6'd0, 7'd0);
        send_item(MODE_READ, 8'h00, 6'd0, 7'd1);
        send_item(MODE_READ, 8'h00, 6'd1, 7'd0);

        // shrink below the cursor: zero clamps to 1, rows ignore bit 7
        wait_drained();
        write_reg(CFG_COLUMNS, 8'h00);
        write_reg(CFG_ROWS, 8'h80);
        cfg_valid <= 1'b0;
        send_item(MODE_WRITE, 8'h71, 6'd0, 7'd0);
        send_item(MODE_WRITE, NEWLINE_BYTE, 6'd0, 7'd0);
        send_item(MODE_WRITE, NEWLINE_BYTE, 6'd0, 7'd0);
        send_item(MODE_WRITE, 8'h7A, 6'd0, 7'd0);
        send_item(MODE_READ, 8'h00, 6'd0, 7'd0);

        // oversize values clamp to the maximum; indexes past the list are ignored
        wait_drained();
        write_reg(CFG_COLUMNS, 8'hC8);
        write_reg(CFG_ROWS, 8'h7F);
        write_reg(CFG_SPARE_A, 8'h55);
        write_reg(CFG_SPARE_B, 8'hAA);
        cfg_valid <= 1'b0;
        send_item(MODE_WRITE, 8'h7E, 6'd0, 7'd0);
        send_item(MODE_READ, 8'h00, 6'd0, 7'd1);
        send_item(MODE_CLEAR, 8'h55, 6'd42, 7'd85);
        send_item(MODE_READ, 8'h00, 6'd0, 7'd1);

        // 3x2 grid: wrap then scroll
        wait_drained();
        write_reg(CFG_ROWS, 8'd2);
        write_reg(CFG_COLUMNS, 8'd3);
        cfg_valid <= 1'b0;
        for (i = 0; i < 7; i++) begin
            send_item(MODE_WRITE, 8'h61 + 8'(i), 6'd0, 7'd0);
        end
        send_item(MODE_READ, 8'h00, 6'd0, 7'd0);

        for (ph = 0; ph < PHASES; ph++) begin
            n_phase = 70;
            nl_pct  = 15;
            case (ph)
                0: begin
                    w = 1;
                    h = 1;
                end
                1: begin
                    // full grid: newline heavy so the cursor reaches the bottom
                    w = 128;
                    h = 64;
                    n_phase = 120;
                    nl_pct = 70;
                end
                2: begin
                    w = 1;
                    h = 64;
                end
                3: begin
                    w = 128;
                    h = 1;
                end
                default: begin
                    if ($urandom_range(0, 3) == 0) begin
                        w = $urandom_range(13, 40);
                        h = $urandom_range(5, 12);
                    end else begin
                        w = $urandom_range(1, 12);
                        h = $urandom_range(1, 6);
                    end
                    nl_pct = $urandom_range(5, 30);
                end
            endcase
            tx_fast = (ph == 5 || ph == 9);
            rx_fast = (ph == 9);

            wait_drained();
            if ($urandom_range(0, 1) == 1) begin
                write_reg(CFG_COLUMNS, 8'(w));
                write_reg(CFG_ROWS, 8'(h));
            end else begin
                write_reg(CFG_ROWS, 8'(h));
                write_reg(CFG_COLUMNS, 8'(w));
            end
            cfg_valid <= 1'b0;
            if (ph == 5) hold_pending = 1'b1;

            for (i = 0; i < n_phase; i++) begin
                r  = $urandom_range(0, 99);
                ch = 8'($urandom);
                rr = 6'($urandom);
                rc = 7'($urandom);
                if (r < 1) begin
                    mode = MODE_CLEAR;
                end else if (r < 3) begin
                    mode = MODE_SPARE;
                end else if (r < 5) begin
                    mode = MODE_WRITE;
                    ch = 8'h00;
                end else if (r < 5 + nl_pct) begin
                    mode = MODE_WRITE;
                    ch = NEWLINE_BYTE;
                end else if (r < 85) begin
                    mode = MODE_WRITE;
                    ch = 8'($urandom_range(1, 255));
                end else begin
                    mode = MODE_READ;
                    // mostly inside the visible area, otherwise anywhere in the store
                    if ($urandom_range(0, 3) != 0) begin
                        rr = 6'($urandom_range(0, h - 1));
                        rc = 7'($urandom_range(0, w - 1));
                    end
                end
                send_item(mode, ch, rr, rc);
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        @(negedge aclk);
        $display("ran %0d input beats and %0d register writes over %0d grid settings",
                 n_sent, n_cfg, PHASES + 4);
        $display("checked %0d results, %0d of them scrolls", mon_results, mon_scrolls);
        if (mon_fails == 0) begin
            $display("text_grid_cursor_scroll_top verification clean");
        end else begin
            $display("text_grid_cursor_scroll_top verification failed");
        end
        $finish;
    end

endmodule
